// ===== rtl/core/rld_pkg.sv =====
package rld_pkg;

    // Depth of the command queue between the front and back parts.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Length byte that marks end of data.
    localparam logic [7:0] EOD_CODE = 8'd128;

    // Decoder phases.
    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_LIT  = 2'd1;
    localparam logic [1:0] PH_REP  = 2'd2;

    // One encoded input transaction.
    typedef struct packed {
        logic [7:0] code_byte;
        logic       buffer_end;
    } t_in;

    // One decoded result transaction.
    typedef struct packed {
        logic [7:0] out_byte0;
        logic [7:0] out_byte1;
        logic [7:0] out_byte2;
        logic [7:0] out_byte3;
        logic [2:0] valid_count;
        logic       last_of_run;
        logic       end_of_data;
    } t_out;

    // Command from the front part: emit data_byte count times, or an end marker.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] count;
        logic       eod;
    } t_cmd;

endpackage

// ===== rtl/core/rld_front.sv =====
module rld_front import rld_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    input  logic i_queue_full,
    output logic o_in_stall,
    output logic o_push,
    output t_cmd o_cmd
);

    logic [1:0] r_phase;
    logic [1:0] n_phase;
    logic [6:0] r_lit_left;
    logic [6:0] n_lit_left;
    logic [7:0] r_rep_count;
    logic [7:0] n_rep_count;
    logic       accept;
    logic [7:0] b;

    // The queue must have room before a transaction is taken.
    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign b          = i_in_data.code_byte;

    // Classify the byte by phase and work out the next phase.
    always_comb begin
        n_phase     = r_phase;
        n_lit_left  = r_lit_left;
        n_rep_count = r_rep_count;
        o_push      = 1'b0;
        o_cmd       = '0;
        case (r_phase)
            PH_LIT: begin
                o_push          = accept;
                o_cmd.data_byte = b;
                o_cmd.count     = 8'd1;
                if (r_lit_left == 7'd0) begin
                    n_phase = PH_WAIT;
                end else begin
                    n_lit_left = r_lit_left - 7'd1;
                end
            end
            PH_REP: begin
                o_push          = accept;
                o_cmd.data_byte = b;
                o_cmd.count     = r_rep_count;
                n_rep_count     = 8'd0;
                n_phase         = PH_WAIT;
            end
            default: begin
                if (b < EOD_CODE) begin
                    n_lit_left = b[6:0];
                    n_phase    = PH_LIT;
                end else if (b > EOD_CODE) begin
                    // 257 minus the length byte, kept in eight bits.
                    n_rep_count = ~b + 8'd2;
                    n_phase     = PH_REP;
                end else begin
                    o_push    = accept;
                    o_cmd.eod = 1'b1;
                    n_phase   = PH_WAIT;
                end
            end
        endcase
        // The last byte of a buffer drops any open literal or run.
        if (i_in_data.buffer_end) begin
            n_phase     = PH_WAIT;
            n_lit_left  = 7'd0;
            n_rep_count = 8'd0;
        end
    end

    // Decoder state advances only on an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_lit_left  <= 7'd0;
            r_rep_count <= 8'd0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_lit_left  <= n_lit_left;
            r_rep_count <= n_rep_count;
        end
    end

endmodule

// ===== rtl/core/rld_queue.sv =====
module rld_queue import rld_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_slot[r_rd_ptr];

    // Command storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/rld_back.sv =====
module rld_back import rld_pkg::*; #(
    parameter int unsigned LANES = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_cmd i_cmd,
    output logic o_pop,
    input  logic i_out_stall,
    output logic o_out_valid,
    output t_out o_out_data
);

    // Bytes per result: the lane count limited to the four byte fields.
    localparam int unsigned LW = (LANES < 1) ? 1 : ((LANES > 4) ? 4 : LANES);

    logic       r_active;
    logic [7:0] r_left;
    logic [7:0] r_byte;
    logic       r_out_valid;
    t_out       r_out;
    logic       out_free;
    logic       emit;
    logic [7:0] cur_left;
    logic [7:0] cur_byte;
    logic       cur_eod;
    logic [7:0] chunk;
    logic [7:0] rem;
    t_out       n_out;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = out_free && !r_active && !i_empty;
    assign emit     = out_free && (r_active || !i_empty);

    // Source of the next result: a run in progress or a fresh command.
    assign cur_left = r_active ? r_left : i_cmd.count;
    assign cur_byte = r_active ? r_byte : i_cmd.data_byte;
    assign cur_eod  = r_active ? 1'b0   : i_cmd.eod;
    assign chunk    = (cur_left > 8'(LW)) ? 8'(LW) : cur_left;
    assign rem      = cur_left - chunk;

    // Build one result; lanes beyond the count read as zero.
    always_comb begin
        n_out             = '0;
        n_out.out_byte0   = (chunk > 8'd0) ? cur_byte : 8'd0;
        n_out.out_byte1   = (chunk > 8'd1) ? cur_byte : 8'd0;
        n_out.out_byte2   = (chunk > 8'd2) ? cur_byte : 8'd0;
        n_out.out_byte3   = (chunk > 8'd3) ? cur_byte : 8'd0;
        n_out.valid_count = chunk[2:0];
        n_out.last_of_run = (rem == 8'd0);
        n_out.end_of_data = cur_eod;
    end

    // Run tracking and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
            if (emit) begin
                r_active <= (rem != 8'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && emit) begin
            r_out  <= n_out;
            r_left <= rem;
            r_byte <= cur_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/run_length_byte_decoder_top.sv =====
// Path: a literal or repeat byte is registered in the command queue, then in the output register.
// Throughput: one byte per cycle for length and literal bytes while the command queue is not full;
// a repeat byte of run N is split by the back part into results of min(LANES, 4) bytes, while the four-entry
// command queue keeps taking input bytes until it fills.
// Reset: synchronous, active low; clears phase, counters, queue and output valid.
module run_length_byte_decoder_top import rld_pkg::*; #(
    parameter int unsigned LANES = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_stall
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd push_cmd;
    t_cmd pop_cmd;

    // Front part: accepts bytes and turns them into commands.
    rld_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .i_queue_full (full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // Command queue between the two parts.
    rld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    // Back part: expands commands into lane-wide results.
    rld_back #(
        .LANES (LANES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_cmd       (pop_cmd),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/core/rld_checker.sv =====
module rld_checker import rld_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input t_in  i_in_data,
    input logic o_in_stall,
    input logic o_out_valid,
    input t_out o_out_data,
    input logic i_out_stall
);

    // A stalled input transaction stays offered with the same payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled input changed");

    // A stalled result transaction holds its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // An end marker carries no bytes and closes its transaction.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.end_of_data |->
            o_out_data.valid_count == 3'd0 && o_out_data.last_of_run)
        else $error("malformed end marker");

    // Only an end marker may carry zero bytes, and never more than four.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.valid_count != 3'd0 || o_out_data.end_of_data)
            && o_out_data.valid_count <= 3'd4)
        else $error("bad byte count");

    // The last lane is zero when the byte count is under four.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.valid_count < 3'd4 |-> o_out_data.out_byte3 == 8'd0)
        else $error("unused lane not zero");

endmodule

bind run_length_byte_decoder_top rld_checker u_rld_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
